@@ rtl/core/slp_pkg.sv @@
`timescale 1ns / 1ps
package slp_pkg;

  // Fixed field widths of the stream and register port
  localparam int CNT_W   = 7;
  localparam int WIDX_W  = 12;
  localparam int DATA_W  = 16;
  localparam int NIDX_W  = 6;
  localparam int ACC_W   = 40;
  localparam int LUT_DEPTH = 1024;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_INPUT_COUNT     = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT    = 2'd1;
  localparam logic [1:0] CFG_ACTIVATION_MODE = 2'd2;

  // Activation codes
  localparam logic ACT_IDENTITY = 1'b0;
  localparam logic ACT_TANH     = 1'b1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_INPUT = 1'b1
  } cmd_kind_t;

  // One classified beat, handed from the front to the back
  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      done;
    logic [CNT_W-1:0]          pos;
    logic [WIDX_W-1:0]         widx;
    logic signed [DATA_W-1:0]  data;
  } slp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] input_count;
    logic [CNT_W-1:0] output_count;
    logic             activation_mode;
  } slp_cfg_t;

  typedef logic signed [DATA_W-1:0] tanh_rom_t [0:LUT_DEPTH-1];

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  // Shift-and-subtract unsigned divide, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a * b) >> 62 from 32-bit limbs
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    lo  = {32'd0, ll[31:0]} | (mid << 32);
    hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // round(4096 * tanh(m / 64)) for m up to 512
  function automatic logic [15:0] tanh_mag(input logic [9:0] m, input logic [63:0] base);
    logic [63:0] r, b, num, den;
    logic [63:0] quo;
    r = ONE_Q62;
    b = base;
    for (int k = 0; k < 10; k++) begin
      if (m[k]) r = mul_q62(r, b);
      b = mul_q62(b, b);
    end
    num = (ONE_Q62 - r) >> 20;
    den = (ONE_Q62 + r) >> 20;
    quo = udiv64(64'd8192 * num + den, 64'd2 * den);
    return quo[15:0];
  endfunction

  // Build the activation table: entry e read as signed 10-bit s
  function automatic tanh_rom_t build_tanh();
    tanh_rom_t   rom;
    logic [63:0] t, s;
    logic [15:0] mag;
    t = ONE_Q62;
    s = ONE_Q62;
    for (int k = 1; k <= 14; k++) begin
      t = udiv64(t, 64'(32 * k));
      if ((k % 2) == 1) s = s - t;
      else              s = s + t;
    end
    for (int e = 0; e < LUT_DEPTH; e++) begin
      if (e < 512) begin
        mag    = tanh_mag(10'(e), s);
        rom[e] = mag;
      end else begin
        mag    = tanh_mag(10'(1024 - e), s);
        rom[e] = -mag;
      end
    end
    return rom;
  endfunction

endpackage

@@ rtl/core/slp_front.sv @@
`timescale 1ns / 1ps
module slp_front import slp_pkg::*; #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,    // weight_index [11:0], data_value [27:12]
  input  logic             s_tuser,    // action
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata,
  output slp_cfg_t         cfg,
  output logic             push_valid,
  input  logic             push_ready,
  output slp_cmd_t         push_cmd
);

  localparam logic [CNT_W-1:0] IN_MAX  = CNT_W'((MAX_INPUTS < 127) ? MAX_INPUTS : 127);
  localparam logic [CNT_W-1:0] OUT_MAX = CNT_W'(MAX_OUTPUTS);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             accept;
  logic             vec_done;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && s_tready;
  assign cnt_inc  = cnt + CNT_W'(1);
  assign vec_done = (cnt_inc >= cfg.input_count);

  // Classify the beat
  always_comb begin
    push_valid    = s_tvalid;
    push_cmd.kind = s_tuser ? CMD_INPUT : CMD_LOAD;
    push_cmd.done = vec_done;
    push_cmd.pos  = cnt;
    push_cmd.widx = s_tdata[11:0];
    push_cmd.data = s_tdata[27:12];
  end

  // Hold configuration registers, clamped to their in-use range
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_count     <= CNT_W'(1);
      cfg.output_count    <= CNT_W'(1);
      cfg.activation_mode <= ACT_TANH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INPUT_COUNT: begin
          if (cfg_wdata == '0)        cfg.input_count <= CNT_W'(1);
          else if (cfg_wdata > IN_MAX) cfg.input_count <= IN_MAX;
          else                        cfg.input_count <= cfg_wdata;
        end
        CFG_OUTPUT_COUNT: begin
          if (cfg_wdata == '0)         cfg.output_count <= CNT_W'(1);
          else if (cfg_wdata > OUT_MAX) cfg.output_count <= OUT_MAX;
          else                         cfg.output_count <= cfg_wdata;
        end
        CFG_ACTIVATION_MODE: cfg.activation_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Count inputs of the current vector; a new input count drops a partial one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cfg_we && cfg_index == CFG_INPUT_COUNT) begin
      cnt <= '0;
    end else if (accept && s_tuser) begin
      cnt <= vec_done ? '0 : cnt_inc;
    end
  end

endmodule

@@ rtl/core/slp_cmd_fifo.sv @@
`timescale 1ns / 1ps
module slp_cmd_fifo import slp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  slp_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_ready,
  output slp_cmd_t pop_cmd
);

  slp_cmd_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_cmd;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/slp_back.sv @@
`timescale 1ns / 1ps
module slp_back import slp_pkg::*; #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  slp_cfg_t    cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  slp_cmd_t    pop_cmd,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // neuron_index [5:0], neuron_value [21:6]
  output logic        m_tlast    // last_output
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam tanh_rom_t TANH_ROM = build_tanh();

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_LUT   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state;

  logic signed [DATA_W-1:0] wmem [1<<WIDX_W];
  logic signed [DATA_W-1:0] xbuf [MAX_INPUTS];

  logic [CNT_W-1:0]         jcnt;
  logic [WIDX_W-1:0]        waddr;
  logic [NW-1:0]            ncnt;
  logic                     v1;
  logic                     v2;
  logic signed [DATA_W-1:0] x_q;
  logic signed [DATA_W-1:0] w_q;
  logic signed [31:0]       prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [ACC_W-13:0] acc_q;
  logic signed [DATA_W-1:0] sat;
  logic signed [DATA_W-1:0] sat_next;
  logic signed [DATA_W-1:0] lut_q;
  logic                     take;
  logic                     wr_weight;
  logic                     wr_input;
  logic                     last_neuron;
  logic                     out_free;

  assign pop_ready   = (state == ST_IDLE);
  assign take        = pop_valid && pop_ready;
  assign wr_weight   = take && (pop_cmd.kind == CMD_LOAD);
  assign wr_input    = take && (pop_cmd.kind == CMD_INPUT);
  assign last_neuron = (CNT_W'(ncnt) == cfg.output_count - CNT_W'(1));
  assign out_free    = !m_tvalid || m_tready;

  // Weight store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_weight) wmem[pop_cmd.widx] <= pop_cmd.data;
    w_q <= wmem[waddr];
  end

  // Input buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_input) xbuf[IW'(pop_cmd.pos)] <= pop_cmd.data;
    x_q <= xbuf[IW'(jcnt)];
  end

  // Activation table read
  always_ff @(posedge clk) begin
    lut_q <= TANH_ROM[sat[15:6]];
  end

  // Round half up to Q4.12 and saturate
  always_comb begin
    acc_rnd = acc + ACC_W'(2048);
    acc_q   = acc_rnd[ACC_W-1:12];
    if (acc_q > (ACC_W-12)'(32767))       sat_next = 16'sh7fff;
    else if (acc_q < -(ACC_W-12)'(32768)) sat_next = 16'sh8000;
    else                                  sat_next = acc_q[DATA_W-1:0];
  end

  // Multiply and accumulate pipeline
  always_ff @(posedge clk) begin
    prod <= 32'(x_q) * 32'(w_q);
    if (state == ST_IDLE) acc <= '0;
    else if (state == ST_EMIT && out_free) acc <= '0;
    else if (v2) acc <= acc + {{(ACC_W-32){prod[31]}}, prod};
    if (state == ST_DRAIN) sat <= sat_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC);
      v2 <= v1;
    end
  end

  // Sequence one vector: neuron by neuron over the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      jcnt  <= '0;
      waddr <= '0;
      ncnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          jcnt  <= '0;
          waddr <= '0;
          ncnt  <= '0;
          if (wr_input && pop_cmd.done) state <= ST_MAC;
        end
        ST_MAC: begin
          waddr <= waddr + WIDX_W'(1);
          if (jcnt == cfg.input_count - CNT_W'(1)) begin
            jcnt  <= '0;
            state <= ST_DRAIN;
          end else begin
            jcnt <= jcnt + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2) state <= ST_LUT;
        end
        ST_LUT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_neuron) begin
              state <= ST_IDLE;
            end else begin
              ncnt  <= ncnt + NW'(1);
              state <= ST_MAC;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata[5:0]   <= NIDX_W'(ncnt);
      m_tdata[21:6]  <= (cfg.activation_mode == ACT_TANH) ? lut_q : sat;
      m_tdata[23:22] <= 2'b00;
      m_tlast        <= last_neuron;
    end
  end

endmodule

@@ rtl/core/single_layer_perceptron_unit.sv @@
`timescale 1ns / 1ps
// Dense layer, Q4.12. Load and input beats enter a two-entry command FIFO and
// are taken while it has room. After the final input beat of a vector, the
// neurons are computed one by one on the single shared multiplier, each through
// the MAC, drain, table and emit states; emit waits while the output is held.
// Synchronous reset clears control and counts and presets the configuration;
// data registers and weight and input stores are not cleared, nor need to be.
module single_layer_perceptron_unit import slp_pkg::*; #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,    // weight_index [11:0], data_value [27:12]
  input  logic             s_tuser,    // action
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,    // neuron_index [5:0], neuron_value [21:6]
  output logic             m_tlast,    // last_output
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_wdata
);

  slp_cfg_t cfg;
  logic     push_valid;
  logic     push_ready;
  slp_cmd_t push_cmd;
  logic     pop_valid;
  logic     pop_ready;
  slp_cmd_t pop_cmd;

  slp_front #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  slp_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  slp_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import slp_pkg::*;

  localparam int QUIET_LIMIT = 5000;   // cycles with no beat on any port
  localparam int LONG_HOLD   = 400;    // output back-pressure stretch
  localparam int SETTLE      = 16;     // idle cycles before a register write
  localparam int TARGET_BEATS = 310;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One stream beat with the sender's idle cycles before it
  typedef struct packed {
    cmd_kind_t          action;
    logic [11:0]        widx;
    logic signed [15:0] data;
    logic [3:0]         gap;
  } layer_beat_t;

  typedef struct packed {
    logic [5:0]         index;
    logic signed [15:0] value;
    logic               last;
  } neuron_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // Layer model state
  logic signed [15:0] model_weights [0:4095];
  logic signed [15:0] model_inputs [0:63];
  logic signed [15:0] tanh_rom [0:1023];
  int  model_fill = 0;
  int  model_ic = 1;
  int  model_oc = 1;
  logic model_act = ACT_TANH;

  layer_beat_t    beat_queue[$];
  neuron_result_t expected_neurons[$];
  bit  weight_loaded [0:4095];
  layer_beat_t tx_beat;
  int  tx_idle = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  int  rx_wait = 0;
  int  hold_left = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  quiet = 0;
  int  mismatches = 0;
  int  beats_planned = 0;
  int  loads_seen = 0;
  int  inputs_seen = 0;
  int  results_seen = 0;
  int  vectors_seen = 0;
  int  settings_done = 0;

  single_layer_perceptron_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one accepted beat into the layer model; a completed vector yields its neurons
  function automatic void apply_beat(input layer_beat_t b);
    logic signed [63:0] acc;
    logic signed [63:0] q;
    logic signed [15:0] v;
    neuron_result_t r;
    int addr;
    if (b.action == CMD_LOAD) begin
      model_weights[b.widx] = b.data;
      return;
    end
    if (model_fill < 64) model_inputs[model_fill] = b.data;
    model_fill++;
    if (model_fill < model_ic) return;
    model_fill = 0;
    for (int i = 0; i < model_oc; i++) begin
      acc = '0;
      for (int j = 0; j < model_ic; j++) begin
        addr = (i * model_ic + j) % 4096;
        acc = acc + model_inputs[j] * model_weights[addr];
      end
      // round half up to Q4.12, then saturate
      q = (acc + 64'sd2048) >>> 12;
      if (q > 64'sd32767) v = 16'sh7FFF;
      else if (q < -64'sd32768) v = 16'sh8000;
      else v = q[15:0];
      if (model_act == ACT_TANH) v = tanh_rom[v[15:6]];
      r.index = 6'(i);
      r.value = v;
      r.last  = (i == model_oc - 1);
      expected_neurons.push_back(r);
    end
  endfunction

  // Sender: present queued beats after their idle gaps, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_idle <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_beat(tx_beat);
        if (tx_beat.action == CMD_LOAD) loads_seen++;
        else inputs_seen++;
      end
      if (!s_tvalid || s_tready) begin
        if (beat_queue.size() != 0 && tx_idle >= beat_queue[0].gap) begin
          tx_beat = beat_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= tx_beat.action;
          s_tdata <= {4'd0, tx_beat.data, tx_beat.widx};
          tx_idle <= 0;
        end else begin
          s_tvalid <= 1'b0;
          if (tx_idle < 64) tx_idle <= tx_idle + 1;
        end
      end
    end
  end

  // Receiver: check each result beat, drive ready with random stalls and one long hold
  always @(posedge clk) begin : rx_side
    int unsigned w;
    neuron_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tlast) vectors_seen++;
        if (expected_neurons.size() == 0) begin
          $error("unexpected result: neuron_index %0d neuron_value %0d",
                 m_tdata[5:0], $signed(m_tdata[21:6]));
          mismatches++;
        end else begin
          e = expected_neurons.pop_front();
          if (m_tdata[5:0] !== e.index) begin
            $error("neuron_index: expected %0d, actual %0d", e.index, m_tdata[5:0]);
            mismatches++;
          end
          if (m_tdata[21:6] !== e.value) begin
            $error("neuron_value: expected %0d, actual %0d", e.value,
                   $signed(m_tdata[21:6]));
            mismatches++;
          end
          if (m_tlast !== e.last) begin
            $error("last_output: expected %0d, actual %0d", e.last, m_tlast);
            mismatches++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done <= holds_done + 1;
        hold_left <= LONG_HOLD;
        m_tready <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        w = rx_burst ? 0 : $urandom_range(0, 6);
        rx_wait <= w;
        m_tready <= (w == 0);
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        m_tready <= (rx_wait == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Abort when no port moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [15:0] random_q412();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom);
      1: v = int'($urandom_range(0, 1023)) - 512;
      2: v = int'($urandom_range(0, 8191)) - 4096;
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  task automatic queue_beat(input cmd_kind_t a, input logic [11:0] idx,
                            input logic signed [15:0] d);
    layer_beat_t b;
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    b.action = a;
    b.widx = idx;
    b.data = d;
    b.gap = tx_burst ? 4'd0 : 4'($urandom_range(0, 6));
    if (a == CMD_LOAD) weight_loaded[idx] = 1'b1;
    beat_queue.push_back(b);
    beats_planned++;
  endtask

  // Load every weight of the current layer shape that was never written
  task automatic load_missing();
    for (int a = 0; a < model_ic * model_oc; a++)
      if (!weight_loaded[a]) queue_beat(CMD_LOAD, 12'(a), random_q412());
  endtask

  // One full input vector, with the odd weight update mixed in
  task automatic queue_vector();
    for (int j = 0; j < model_ic; j++) begin
      if ($urandom_range(0, 7) == 0)
        queue_beat(CMD_LOAD, 12'($urandom_range(0, model_ic * model_oc - 1)),
                   random_q412());
      queue_beat(CMD_INPUT, 12'($urandom_range(0, 4095)), random_q412());
    end
  endtask

  // Hold until every beat is accepted and every expected result has arrived
  task automatic wait_results();
    do @(posedge clk);
    while (beat_queue.size() != 0 || s_tvalid || expected_neurons.size() != 0);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INPUT_COUNT: begin
        model_ic = (val == 0) ? 1 : (val > 64) ? 64 : int'(val);
        model_fill = 0;
      end
      CFG_OUTPUT_COUNT: model_oc = (val == 0) ? 1 : (val > 64) ? 64 : int'(val);
      CFG_ACTIVATION_MODE: model_act = val[0];
      default: ;
    endcase
  endtask

  task automatic set_layer(input logic [6:0] ic_raw, input logic [6:0] oc_raw,
                           input logic [6:0] act_raw);
    settle();
    program_reg(CFG_INPUT_COUNT, ic_raw);
    program_reg(CFG_OUTPUT_COUNT, oc_raw);
    program_reg(CFG_ACTIVATION_MODE, act_raw);
    settings_done++;
  endtask

  initial begin : stimulus
    int mag;
    int ic_raw;
    int oc_raw;
    int nvec;
    // Activation table: entry e read as signed 10-bit s holds round(4096*tanh(s/64))
    for (int e = 0; e < 1024; e++) begin
      mag = (e < 512) ? e : 1024 - e;
      mag = $rtoi($floor(4096.0 * $tanh(mag / 64.0) + 0.5));
      tanh_rom[e] = (e < 512) ? 16'(mag) : 16'(-mag);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settings_done = 1;

    // Reset shape (one input, one neuron, tanh): saturation at both ends
    queue_beat(CMD_LOAD, 12'd0, 16'sh7FFF);
    queue_beat(CMD_LOAD, 12'd4095, 16'sh8000);
    queue_beat(CMD_INPUT, 12'd0, 16'sh7FFF);
    queue_beat(CMD_INPUT, 12'hFFF, 16'sh8000);

    // Identity: rounding around the half step, saturation, exact one
    settle();
    program_reg(CFG_UNUSED, 7'h55);
    set_layer(7'd1, 7'd1, 7'(ACT_IDENTITY));
    queue_beat(CMD_LOAD, 12'd0, 16'sd1);
    queue_beat(CMD_INPUT, 12'd0, 16'sd2047);
    queue_beat(CMD_INPUT, 12'd0, 16'sd2048);
    queue_beat(CMD_INPUT, 12'd0, -16'sd2048);
    queue_beat(CMD_INPUT, 12'd0, -16'sd2049);
    queue_beat(CMD_LOAD, 12'd0, 16'sh8000);
    queue_beat(CMD_INPUT, 12'd0, 16'sh8000);
    queue_beat(CMD_INPUT, 12'd0, 16'sh7FFF);
    queue_beat(CMD_LOAD, 12'd0, 16'sd4096);
    queue_beat(CMD_INPUT, 12'd0, 16'sd0);

    // Two by two in tanh
    set_layer(7'd2, 7'd2, 7'(ACT_TANH));
    queue_beat(CMD_LOAD, 12'd1, 16'sd4096);
    queue_beat(CMD_LOAD, 12'd2, -16'sd4096);
    queue_beat(CMD_LOAD, 12'd3, 16'sd2048);
    queue_beat(CMD_INPUT, 12'd0, 16'sd1024);
    queue_beat(CMD_INPUT, 12'd0, -16'sd3000);

    // Widest input: count written above range saturates to 64
    set_layer(7'd127, 7'd1, 7'(ACT_IDENTITY));
    load_missing();
    queue_vector();

    // Most neurons, input count written as zero; hold the output off meanwhile
    set_layer(7'd0, 7'd100, 7'(ACT_TANH));
    for (int k = 0; k < 4; k++)
      queue_beat(CMD_LOAD, 12'($urandom_range(0, 63)), random_q412());
    holds_asked++;
    for (int k = 0; k < 4; k++) queue_vector();
    wait_results();
    queue_vector();
    queue_vector();

    set_layer(7'd1, 7'd127, 7'h7E);
    for (int k = 0; k < 3; k++) queue_vector();

    // Random shapes, with pauses and broken vectors dropped by the next count write
    while (beats_planned < TARGET_BEATS) begin
      ic_raw = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      oc_raw = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
      set_layer(7'(ic_raw), 7'(oc_raw), 7'($urandom_range(0, 127)));
      load_missing();
      for (int k = $urandom_range(2, 6); k > 0; k--) begin
        if ($urandom_range(0, 2) == 0)
          queue_beat(CMD_LOAD, 12'($urandom_range(0, 4095)), random_q412());
        else
          queue_beat(CMD_LOAD, 12'($urandom_range(0, model_ic * model_oc - 1)),
                     random_q412());
      end
      nvec = $urandom_range(2, 5);
      for (int v = 0; v < nvec; v++) begin
        queue_vector();
        if ($urandom_range(0, 2) == 0) wait_results();
      end
      if (model_ic > 1 && $urandom_range(0, 2) == 0)
        for (int k = $urandom_range(1, model_ic - 1); k > 0; k--)
          queue_beat(CMD_INPUT, 12'($urandom_range(0, 4095)), random_q412());
    end

    settle();
    repeat (100) @(posedge clk);
    $display("Covered %0d weight loads, %0d input values, %0d neuron results in %0d vectors",
             loads_seen, inputs_seen, results_seen, vectors_seen);
    $display("over %0d layer settings: both activations, counts 1 to 64, long output hold",
             settings_done);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
